// ----- hw/rtl/mpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_pkg: shared types and constants of the min-heap priority queue
// Action and status codes, fixed field widths, controller states.
// ----------------------------------------------------------------------------
package mpq_pkg;

  // default sizing
  localparam int DEF_CAPACITY  = 64;
  localparam int DEF_KEY_WIDTH = 16;
  localparam int DEF_ID_WIDTH  = 16;

  // fixed field widths of the channels
  localparam int ACT_W  = 2;
  localparam int TAG_W  = 16;
  localparam int PRIO_W = 16;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 2'd0,
    ACT_EXTRACT = 2'd1,
    ACT_REMOVE  = 2'd2
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EX_ROOT,
    ST_LOAD,
    ST_SCAN,
    ST_UP_RD,
    ST_UP_CK,
    ST_DN_RD,
    ST_DN_L,
    ST_DN_R,
    ST_FIN,
    ST_RESP
  } state_e;

endpackage

// ----- hw/rtl/mpq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_if: request and response channels of the priority queue
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mpq_req_if;
  import mpq_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [TAG_W-1:0]  item_id;
  logic [PRIO_W-1:0] item_key;

  modport source (output valid, output action, output item_id, output item_key,
                  input ready);
  modport sink   (input valid, input action, input item_id, input item_key,
                  output ready);
endinterface

interface mpq_rsp_if;
  import mpq_pkg::*;

  logic              valid;
  logic              ready;
  logic [TAG_W-1:0]  out_id;
  logic [PRIO_W-1:0] out_key;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, output out_id, output out_key, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input out_id, input out_key, input status,
                  input entry_count, output ready);
endinterface

// ----- hw/rtl/min_heap_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue: binary min-heap of (id, key) entries
// Insert, extract-minimum and remove-by-id over a heap held in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one action per beat (insert, extract minimum, remove by id);
//   rsp_o returns exactly one beat per request with the extracted entry, a
//   status code and the entry count after the action.
//   One request is worked at a time; req_i.ready is high while the controller
//   is idle, also while an earlier response still waits in the output register.
//   The work is paced by the entry memory, one read per cycle: an insert
//   climbs levels, an extract descends them, and a remove scans the held
//   entries, then sifts up and down.
//   Reset empties the heap at once; no clearing pass runs, since only held
//   entries are ever read.
//   When the receiver stalls, a finished response holds in the output register;
//   the controller waits only while an earlier response still holds it.
// ----------------------------------------------------------------------------
module min_heap_priority_queue #(
  parameter int CAPACITY  = mpq_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = mpq_pkg::DEF_KEY_WIDTH,
  parameter int ID_WIDTH  = mpq_pkg::DEF_ID_WIDTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mpq_req_if.sink   req_i,
  mpq_rsp_if.source rsp_o
);
  import mpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam int EW = ID_WIDTH + KEY_WIDTH;

  state_e state_q, state_d;

  logic [AW-1:0]        pos_q, pos_d;
  logic [CW-1:0]        fill_q, fill_d;
  logic [CW-1:0]        scan_q, scan_d;
  logic [AW-1:0]        chk_q, chk_d;
  logic                 pend_q, pend_d;
  logic                 mode_q, mode_d;
  logic [ID_WIDTH-1:0]  tag_q, tag_d;
  logic [ID_WIDTH-1:0]  ent_id_q, ent_id_d;
  logic [KEY_WIDTH-1:0] ent_key_q, ent_key_d;
  logic [ID_WIDTH-1:0]  lid_q, lid_d;
  logic [KEY_WIDTH-1:0] lkey_q, lkey_d;
  logic [ID_WIDTH-1:0]  rid_q, rid_d;
  logic [KEY_WIDTH-1:0] rkey_q, rkey_d;
  status_e              sts_q, sts_d;

  logic              out_vld_q, out_vld_d;
  logic [TAG_W-1:0]  out_id_q, out_id_d;
  logic [PRIO_W-1:0] out_key_q, out_key_d;
  logic [STAT_W-1:0] out_sts_q, out_sts_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  mpq_mem #(
    .Depth (CAPACITY),
    .Width (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // shared decode
  logic                 in_fire, out_free;
  action_e              act;
  logic                 full, empty;
  logic [ID_WIDTH-1:0]  rd_id;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [AW-1:0]        parent;
  logic [XW-1:0]        lidx, ridx;
  logic                 has_l, has_r;
  logic                 up_move;
  logic                 hit, last_hit, scan_more;
  logic                 in_r, use_r, use_lreg, swap;
  logic [KEY_WIDTH-1:0] pick_key;
  logic [EW-1:0]        pick_data;
  logic [AW-1:0]        pick_idx;
  logic [CW-1:0]        fill_m1;

  assign in_fire   = req_i.valid && req_i.ready;
  assign out_free  = !out_vld_q || rsp_o.ready;
  assign act       = action_e'(req_i.action);
  assign full      = (fill_q == CW'(CAPACITY));
  assign empty     = (fill_q == '0);
  assign fill_m1   = fill_q - 1'b1;
  assign rd_key    = mem_rdata[KEY_WIDTH-1:0];
  assign rd_id     = mem_rdata[EW-1:KEY_WIDTH];
  assign parent    = (pos_q - 1'b1) >> 1;
  assign lidx      = {1'b0, pos_q, 1'b1};
  assign ridx      = lidx + 1'b1;
  assign has_l     = lidx < XW'(fill_q);
  assign has_r     = ridx < XW'(fill_q);
  assign up_move   = rd_key > ent_key_q;
  assign hit       = pend_q && (rd_id == tag_q);
  assign last_hit  = (CW'(chk_q) == fill_m1);
  assign scan_more = scan_q < fill_q;

  // child choice: right only when strictly smaller
  assign in_r      = (state_q == ST_DN_R);
  assign use_r     = in_r && (rd_key < lkey_q);
  assign use_lreg  = in_r && !use_r;
  assign pick_key  = use_lreg ? lkey_q : rd_key;
  assign pick_data = use_lreg ? {lid_q, lkey_q} : mem_rdata;
  assign pick_idx  = use_r ? ridx[AW-1:0] : lidx[AW-1:0];
  assign swap      = ent_key_q > pick_key;

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.out_id      = out_id_q;
  assign rsp_o.out_key     = out_key_q;
  assign rsp_o.status      = out_sts_q;
  assign rsp_o.entry_count = out_cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (act)
            ACT_INSERT:  state_d = full ? ST_RESP : ST_UP_RD;
            ACT_EXTRACT: state_d = empty ? ST_RESP : ST_EX_ROOT;
            ACT_REMOVE:  state_d = ST_SCAN;
            default:     state_d = ST_RESP;
          endcase
        end
      end
      ST_EX_ROOT: state_d = empty ? ST_RESP : ST_LOAD;
      ST_LOAD:    state_d = mode_q ? ST_UP_RD : ST_DN_RD;
      ST_SCAN: begin
        if (hit) begin
          state_d = last_hit ? ST_RESP : ST_LOAD;
        end else if (!scan_more) begin
          state_d = ST_RESP;
        end
      end
      ST_UP_RD: begin
        if (pos_q != '0) begin
          state_d = ST_UP_CK;
        end else begin
          state_d = mode_q ? ST_DN_RD : ST_FIN;
        end
      end
      ST_UP_CK: begin
        if (up_move) begin
          state_d = ST_UP_RD;
        end else begin
          state_d = mode_q ? ST_DN_RD : ST_FIN;
        end
      end
      ST_DN_RD: state_d = has_l ? ST_DN_L : ST_FIN;
      ST_DN_L: begin
        if (has_r) begin
          state_d = ST_DN_R;
        end else begin
          state_d = swap ? ST_DN_RD : ST_FIN;
        end
      end
      ST_DN_R: state_d = swap ? ST_DN_RD : ST_FIN;
      ST_FIN:  state_d = ST_RESP;
      ST_RESP: state_d = out_free ? ST_IDLE : ST_RESP;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    pos_d     = pos_q;
    fill_d    = fill_q;
    scan_d    = scan_q;
    chk_d     = chk_q;
    pend_d    = pend_q;
    mode_d    = mode_q;
    tag_d     = tag_q;
    ent_id_d  = ent_id_q;
    ent_key_d = ent_key_q;
    lid_d     = lid_q;
    lkey_d    = lkey_q;
    rid_d     = rid_q;
    rkey_d    = rkey_q;
    sts_d     = sts_q;
    out_vld_d = out_vld_q;
    out_id_d  = out_id_q;
    out_key_d = out_key_q;
    out_sts_d = out_sts_q;
    out_cnt_d = out_cnt_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = {ent_id_q, ent_key_q};
    mem_re    = 1'b0;
    mem_raddr = '0;

    // response beat taken
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rid_d  = '0;
          rkey_d = '0;
          sts_d  = STS_OK;
          tag_d  = ID_WIDTH'(req_i.item_id);
          mode_d = 1'b0;
          unique case (act)
            ACT_INSERT: begin
              if (full) begin
                sts_d = STS_FULL;
              end else begin
                ent_id_d  = ID_WIDTH'(req_i.item_id);
                ent_key_d = KEY_WIDTH'(req_i.item_key);
                pos_d     = fill_q[AW-1:0];
                fill_d    = fill_q + 1'b1;
              end
            end
            ACT_EXTRACT: begin
              if (empty) begin
                sts_d = STS_EMPTY;
              end else begin
                mem_re = 1'b1;
                pos_d  = '0;
                fill_d = fill_m1;
              end
            end
            ACT_REMOVE: begin
              scan_d = '0;
              pend_d = 1'b0;
              mode_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_EX_ROOT: begin
        rid_d  = rd_id;
        rkey_d = rd_key;
        if (!empty) begin
          mem_re    = 1'b1;
          mem_raddr = fill_q[AW-1:0];
        end
      end
      ST_LOAD: begin
        ent_id_d  = rd_id;
        ent_key_d = rd_key;
      end
      ST_SCAN: begin
        if (hit) begin
          pos_d  = chk_q;
          fill_d = fill_m1;
          if (!last_hit) begin
            mem_re    = 1'b1;
            mem_raddr = fill_m1[AW-1:0];
          end
        end else if (scan_more) begin
          mem_re    = 1'b1;
          mem_raddr = scan_q[AW-1:0];
          chk_d     = scan_q[AW-1:0];
          pend_d    = 1'b1;
          scan_d    = scan_q + 1'b1;
        end else begin
          sts_d = STS_NOT_FOUND;
        end
      end
      ST_UP_RD: begin
        if (pos_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = parent;
        end
      end
      ST_UP_CK: begin
        // parent moves down into the hole
        if (up_move) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          pos_d     = parent;
        end
      end
      ST_DN_RD: begin
        if (has_l) begin
          mem_re    = 1'b1;
          mem_raddr = lidx[AW-1:0];
        end
      end
      ST_DN_L: begin
        lid_d  = rd_id;
        lkey_d = rd_key;
        if (has_r) begin
          mem_re    = 1'b1;
          mem_raddr = ridx[AW-1:0];
        end else if (swap) begin
          mem_we    = 1'b1;
          mem_wdata = pick_data;
          pos_d     = pick_idx;
        end
      end
      ST_DN_R: begin
        // chosen child moves up into the hole
        if (swap) begin
          mem_we    = 1'b1;
          mem_wdata = pick_data;
          pos_d     = pick_idx;
        end
      end
      ST_FIN: begin
        mem_we = 1'b1;
      end
      ST_RESP: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_id_d  = TAG_W'(rid_q);
          out_key_d = PRIO_W'(rkey_q);
          out_sts_d = sts_q;
          out_cnt_d = CNT_W'(fill_q);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      mode_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      out_vld_q <= out_vld_d;
      pend_q    <= pend_d;
      mode_q    <= mode_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    scan_q    <= scan_d;
    chk_q     <= chk_d;
    tag_q     <= tag_d;
    ent_id_q  <= ent_id_d;
    ent_key_q <= ent_key_d;
    lid_q     <= lid_d;
    lkey_q    <= lkey_d;
    rid_q     <= rid_d;
    rkey_q    <= rkey_d;
    sts_q     <= sts_d;
    out_id_q  <= out_id_d;
    out_key_q <= out_key_d;
    out_sts_q <= out_sts_d;
    out_cnt_q <= out_cnt_d;
  end

endmodule

// ----- hw/rtl/mpq_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_mem: heap entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpq_mem #(
  parameter int Depth = 64,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- sim/mpq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_checker: response checker of the min-heap priority queue
// Watches both channels, keeps its own heap image to predict each response
// and compares every response beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mpq_checker #(
  parameter int CAPACITY = mpq_pkg::DEF_CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mpq_req_if.sink    req_i,
  mpq_rsp_if.sink    rsp_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         held_o
);
  import mpq_pkg::*;

  typedef struct packed {
    logic [TAG_W-1:0]  id;
    logic [PRIO_W-1:0] key;
    status_e           status;
    logic [CNT_W-1:0]  count;
  } answer_t;

  answer_t          answer_q[$];
  logic [PRIO_W-1:0] img_key[CAPACITY];
  logic [TAG_W-1:0]  img_id[CAPACITY];
  int               img_fill;

  assign pending_o = answer_q.size();
  assign held_o    = img_fill;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
    fail_count_o++;
  endtask

  function automatic void swap_slots(input int a, input int b);
    logic [PRIO_W-1:0] k;
    logic [TAG_W-1:0]  d;
    k = img_key[a]; img_key[a] = img_key[b]; img_key[b] = k;
    d = img_id[a];  img_id[a]  = img_id[b];  img_id[b]  = d;
  endfunction

  function automatic int bubble_up(input int pos);
    int up;
    while (pos != 0) begin
      up = (pos - 1) / 2;
      if (img_key[up] <= img_key[pos]) break;
      swap_slots(up, pos);
      pos = up;
    end
    return pos;
  endfunction

  function automatic void bubble_down(input int pos);
    int pick;
    while (2 * pos + 1 < img_fill) begin
      pick = 2 * pos + 1;
      if (pick + 1 < img_fill && img_key[pick + 1] < img_key[pick]) pick++;
      if (img_key[pos] <= img_key[pick]) break;
      swap_slots(pos, pick);
      pos = pick;
    end
  endfunction

  // apply one request to the heap image and form its response
  function automatic answer_t apply_action(input logic [ACT_W-1:0] act,
                                           input logic [TAG_W-1:0] id,
                                           input logic [PRIO_W-1:0] key);
    answer_t a;
    int pos;
    a = '{id: '0, key: '0, status: STS_OK, count: '0};
    case (act)
      ACT_INSERT: begin
        if (img_fill >= CAPACITY) begin
          a.status = STS_FULL;
        end else begin
          img_key[img_fill] = key;
          img_id[img_fill]  = id;
          img_fill++;
          void'(bubble_up(img_fill - 1));
        end
      end
      ACT_EXTRACT: begin
        if (img_fill == 0) begin
          a.status = STS_EMPTY;
        end else begin
          a.id  = img_id[0];
          a.key = img_key[0];
          img_fill--;
          img_key[0] = img_key[img_fill];
          img_id[0]  = img_id[img_fill];
          bubble_down(0);
        end
      end
      ACT_REMOVE: begin
        pos = 0;
        while (pos < img_fill && img_id[pos] != id) pos++;
        if (pos >= img_fill) begin
          a.status = STS_NOT_FOUND;
        end else begin
          img_fill--;
          if (pos != img_fill) begin
            img_key[pos] = img_key[img_fill];
            img_id[pos]  = img_id[img_fill];
            bubble_down(bubble_up(pos));
          end
        end
      end
      default: ;
    endcase
    a.count = CNT_W'(img_fill);
    return a;
  endfunction

  // predict on request beats, compare on response beats
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      answer_q.delete();
      img_fill     <= 0;
      fail_count_o <= 0;
    end else begin
      if (req_i.valid && req_i.ready)
        answer_q.push_back(apply_action(req_i.action, req_i.item_id, req_i.item_key));
      if (rsp_i.valid && rsp_i.ready) begin
        if (answer_q.size() == 0) begin
          $display("response beat with nothing expected (t=%0t)", $time);
          fail_count_o++;
        end else begin
          want = answer_q.pop_front();
          if (rsp_i.out_id !== want.id) report("out_id", rsp_i.out_id, want.id);
          if (rsp_i.out_key !== want.key) report("out_key", rsp_i.out_key, want.key);
          if (rsp_i.status !== want.status) report("status", rsp_i.status, want.status);
          if (rsp_i.entry_count !== want.count)
            report("entry_count", rsp_i.entry_count, want.count);
        end
      end
    end
  end

endmodule

// ----- sim/min_heap_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_tb: top of the priority queue testbench
// Drives directed then random request beats with random gaps and response
// stalls; the checker predicts and compares, this top gives the verdict.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_tb;
  import mpq_pkg::*;

  localparam int CAP       = DEF_CAPACITY;
  localparam int N_RANDOM  = 2000;
  localparam int IDLE_MAX  = 20000;
  localparam int DRAIN_CYC = 200;

  // action code with no meaning, must be ignored
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, held;
  int   quiet_cycles;

  mpq_req_if req ();
  mpq_rsp_if rsp ();

  min_heap_priority_queue u_dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .req_i (req.sink), .rsp_o (rsp.source)
  );

  mpq_checker #(.CAPACITY(CAP)) u_checker (
    .clk_i (clk_i), .rst_ni (rst_ni), .req_i (req.sink), .rsp_i (rsp.sink),
    .fail_count_o (fail_count), .pending_o (pending), .held_o (held)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // small id pool so removes find their targets
  logic [TAG_W-1:0] ids_used[$];

  // send one request beat after a random gap
  task automatic send(input logic [ACT_W-1:0] act, input logic [TAG_W-1:0] id,
                      input logic [PRIO_W-1:0] key);
    repeat ($urandom_range(0, 6)) @(posedge clk_i);
    req.valid    <= 1'b1;
    req.action   <= act;
    req.item_id  <= id;
    req.item_key <= key;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    req.valid <= 1'b0;
    if (act == ACT_INSERT) ids_used.push_back(id);
  endtask

  function automatic logic [TAG_W-1:0] known_id();
    if (ids_used.size() == 0) return TAG_W'($urandom_range(0, 65535));
    return ids_used[$urandom_range(0, ids_used.size() - 1)];
  endfunction

  // receiver waits a random number of cycles before taking each beat
  always begin
    int gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      rsp.ready <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rsp.ready <= 1'b1;
    @(posedge clk_i);
    while (!rsp.valid) @(posedge clk_i);
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_MAX) begin
      $display("[min_heap_priority_queue] ERROR");
      $finish;
    end
  end

  initial begin
    int r, k, burst;
    logic [TAG_W-1:0]  id;
    logic [PRIO_W-1:0] key;
    quiet_cycles  = 0;
    req.valid     = 1'b0;
    req.action    = ACT_INSERT;
    req.item_id   = '0;
    req.item_key  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty cases, extremes, unused code, last-entry remove
    send(ACT_EXTRACT, 16'h1234, 16'h0);
    send(ACT_REMOVE, 16'h0001, 16'h0);
    send(ACT_SPARE, 16'hFFFF, 16'hFFFF);
    send(ACT_INSERT, 16'hFFFF, 16'hFFFF);
    send(ACT_INSERT, 16'h0000, 16'h0000);
    send(ACT_INSERT, 16'hAAAA, 16'h5555);
    send(ACT_INSERT, 16'h5555, 16'hAAAA);
    send(ACT_INSERT, 16'h5555, 16'h0000);
    send(ACT_REMOVE, 16'h5555, 16'h0);
    send(ACT_REMOVE, 16'h5555, 16'h0);
    send(ACT_REMOVE, 16'h7777, 16'h0);
    send(ACT_EXTRACT, 16'h0, 16'h0);
    send(ACT_EXTRACT, 16'h0, 16'h0);
    send(ACT_EXTRACT, 16'h0, 16'h0);
    send(ACT_INSERT, 16'h0042, 16'h0010);
    send(ACT_REMOVE, 16'h0042, 16'h0);
    // fill to capacity and past it
    for (k = 0; k < CAP + 2; k++)
      send(ACT_INSERT, TAG_W'(k), PRIO_W'($urandom_range(0, 65535)));

    // hold off until every response is back
    while (pending != 0) @(posedge clk_i);

    // random: phases biased to grow or shrink the heap
    for (r = 0; r < N_RANDOM; r++) begin
      burst = (r / 200) % 2;
      k = $urandom_range(0, 99);
      if (k < 2) begin
        send(ACT_SPARE, TAG_W'($urandom_range(0, 65535)),
             PRIO_W'($urandom_range(0, 65535)));
      end else if (k < (burst ? 55 : 30)) begin
        id  = ($urandom_range(0, 3) == 0) ? TAG_W'($urandom_range(0, 65535))
                                          : TAG_W'($urandom_range(0, 47));
        key = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom_range(0, 65535))
                                          : PRIO_W'($urandom_range(0, 15));
        send(ACT_INSERT, id, key);
      end else if (k < (burst ? 80 : 70)) begin
        send(ACT_EXTRACT, TAG_W'($urandom_range(0, 65535)), '0);
      end else begin
        id = ($urandom_range(0, 4) == 0) ? TAG_W'($urandom_range(0, 65535)) : known_id();
        send(ACT_REMOVE, id, PRIO_W'($urandom_range(0, 65535)));
      end
    end

    // drain, then settle
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[min_heap_priority_queue] OK");
    end else begin
      $display("[min_heap_priority_queue] ERROR");
    end
    $finish;
  end

endmodule
